@@ src/dsrm_pkg.sv @@
// Package for the dot-star regex matcher.
// Holds pattern character codes, input codes, configuration indexes and the item type.
// No dependencies.
package dsrm_pkg;

  localparam int PAT_CHARS = 16;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_CHAR  = 1'b1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] text_char;
  } item_t;

  function automatic logic char_fits(input logic [7:0] pc, input logic [7:0] tc);
    return (pc == DOT_CHAR) || (pc == tc);
  endfunction

endpackage

@@ src/dot_star_regex_matcher_unit.sv @@
// Top level of the dot-star regex matcher: configuration registers, input beat
// register, match row register and result register. Depends on dsrm_pkg and dsrm_row_update.
//
// The block matches the text received since the last begin beat against the whole
// pattern held in configuration, where '.' matches any byte and 'x*' matches zero or
// more of x. It takes one input beat every clock cycle unless in_stall is high and gives
// one result beat for each, via the input beat register and then the result register. The
// rate is set by the match row register, updated by one pass of the row logic per beat.
// There is no clearing pass after reset; configuration writes are always ready.
module dot_star_regex_matcher_unit #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [7:0]                         text_char,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               whole_match,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dsrm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dsrm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dsrm_pkg::*;

  localparam int IDX_W = $clog2(PATTERN_MAX + 1);

  logic [4:0]           pattern_length;
  logic [63:0]          pattern_low_chars;
  logic [63:0]          pattern_high_chars;
  logic                 s1_valid;
  item_t                s1_item;
  logic [PATTERN_MAX:0] row;
  logic [PATTERN_MAX:0] row_next;
  logic [IDX_W-1:0]     used_len;
  logic                 s1_advance;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_comb begin
    if (32'(pattern_length) > 32'(PATTERN_MAX)) begin
      used_len = IDX_W'(PATTERN_MAX);
    end else begin
      used_len = IDX_W'(pattern_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_low_chars  <= '0;
      pattern_high_chars <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length     <= cfg_data[4:0];
        CFG_PATTERN_LOW:    pattern_low_chars  <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.func      <= func;
      s1_item.text_char <= text_char;
    end
  end

  dsrm_row_update #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_row_update (
    .pattern_low_chars  (pattern_low_chars),
    .pattern_high_chars (pattern_high_chars),
    .item               (s1_item),
    .row                (row),
    .row_next           (row_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (s1_advance) begin
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      whole_match <= row_next[used_len];
    end
  end

endmodule

@@ src/dsrm_row_update.sv @@
// Next-row logic of the prefix match table for one input beat.
// Depends on dsrm_pkg.
module dsrm_row_update #(
  parameter int PATTERN_MAX = 16
) (
  input  logic [63:0]          pattern_low_chars,
  input  logic [63:0]          pattern_high_chars,
  input  dsrm_pkg::item_t      item,
  input  logic [PATTERN_MAX:0] row,
  output logic [PATTERN_MAX:0] row_next
);
  import dsrm_pkg::*;

  logic [7:0] chars [PATTERN_MAX];
  logic       is_begin;

  assign is_begin    = (item.func == FUNC_BEGIN);
  assign row_next[0] = is_begin;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
    if (j < 8) begin : g_low
      assign chars[j] = pattern_low_chars[8*j +: 8];
    end else if (j < PAT_CHARS) begin : g_high
      assign chars[j] = pattern_high_chars[8*(j-8) +: 8];
    end else begin : g_zero
      assign chars[j] = 8'h00;
    end

    if (j == 0) begin : g_first
      assign row_next[1] = !is_begin &&
                           ((chars[0] != STAR_CHAR) ?
                            (row[0] && char_fits(chars[0], item.text_char)) :
                            row_next[0]);
    end else begin : g_rest
      assign row_next[j+1] =
        is_begin ? ((chars[j] == STAR_CHAR) && row_next[j-1]) :
        (chars[j] != STAR_CHAR) ? (row[j] && char_fits(chars[j], item.text_char)) :
        (row_next[j-1] || row_next[j] ||
         (row[j+1] && char_fits(chars[j-1], item.text_char)));
    end
  end

endmodule
